>>> rtl/miu_pkg.sv
// ----------------------------------------------------------------------------
// miu_pkg
// Types and constants shared by the integer execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package miu_pkg;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3,
		OP_AND = 6'd4, OP_ANDI = 6'd5, OP_BEQ = 6'd6, OP_BNE = 6'd7,
		OP_BNEZ = 6'd8, OP_J = 6'd9, OP_JAL = 6'd10, OP_JR = 6'd11,
		OP_LHU = 6'd12, OP_LL = 6'd13, OP_LUI = 6'd14, OP_LW = 6'd15,
		OP_NOR = 6'd16, OP_OR = 6'd17, OP_ORI = 6'd18, OP_SLT = 6'd19,
		OP_SLTI = 6'd20, OP_SLTIU = 6'd21, OP_SLTU = 6'd22, OP_SLL = 6'd23,
		OP_SRL = 6'd24, OP_SW = 6'd25, OP_SUB = 6'd26, OP_SUBU = 6'd27,
		OP_DIV = 6'd28, OP_DIVU = 6'd29, OP_MFHI = 6'd30, OP_MFLO = 6'd31,
		OP_MULT = 6'd32, OP_MULTU = 6'd33, OP_MOVE = 6'd34, OP_LI = 6'd35
	} op_t;

	localparam logic [4:0]  LINK_REG  = 5'd31;
	localparam logic [31:0] SEG_MASK  = 32'hF000_0000;

	typedef struct packed {
		logic [5:0]  operation;
		logic [4:0]  source_reg;
		logic [4:0]  target_reg;
		logic [4:0]  dest_reg;
		logic [4:0]  shift_amount;
		logic [15:0] imm16;
		logic [25:0] jump_target;
		logic [31:0] full_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        branch_taken;
		logic        reg_write_enable;
		logic [4:0]  reg_write_index;
		logic [31:0] reg_write_value;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic        mem_write_enable;
		logic [11:0] mem_word_index;
		logic        divide_by_zero;
		logic        address_fault;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_MEM, ST_DONE
	} exec_state_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage
`default_nettype wire

>>> rtl/mips_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_integer_execute_unit
// MIPS32 integer execute subset with register file, hi/lo, PC and data memory.
// ----------------------------------------------------------------------------
// One instruction is executed at a time. A simple operation steps from
// acceptance to result through fetch operands, execute and retire; loads
// add a state for the registered memory read, multiply adds the 16-bit
// partial products and divide adds the radix-2 divider.
// A two-entry queue accepts further instructions while one executes.
// Writing cfg_data with cfg_valid loads the program counter at once.
`default_nettype none
module mips_integer_execute_unit
	import miu_pkg::*;
#(
	parameter int DATA_WORDS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data
);

	in_item_t q_data;
	logic     q_valid, q_pop;

	assign cfg_ready = 1'b1;

	miu_front u_front (
		.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.q_data, .q_valid, .q_pop
	);

	miu_back #(.DATA_WORDS(DATA_WORDS)) u_back (
		.clk, .arst_n, .cfg_we(cfg_valid), .cfg_data,
		.q_data, .q_valid, .q_pop, .out_data, .out_valid, .out_ready
	);

endmodule
`default_nettype wire

>>> rtl/miu_front.sv
// ----------------------------------------------------------------------------
// miu_front
// Two-entry input queue between the handshake and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none
module miu_front
	import miu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t in_data,
	input  wire logic     in_valid,
	output logic          in_ready,
	output in_item_t      q_data,
	output logic          q_valid,
	input  wire logic     q_pop
);

	in_item_t   slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

endmodule
`default_nettype wire

>>> rtl/miu_muldiv.sv
// ----------------------------------------------------------------------------
// miu_muldiv
// Multi-cycle multiply (16x32 partial products) and radix-2 divider.
// ----------------------------------------------------------------------------
`default_nettype none
module miu_muldiv (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start_mul,
	input  wire logic        start_div,
	input  wire logic        is_signed,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             done,
	output logic [31:0]      hi,
	output logic [31:0]      lo
);

	logic        busy_q, mul_q, neg_q, negr_q;
	logic [5:0]  cnt_q;
	logic [31:0] ma_q, mb_q, rem_q, quo_q;
	logic [63:0] acc_q;
	logic [31:0] aa, ab;
	logic [33:0] trial;
	logic [63:0] prod, res;
	logic [47:0] part;

	assign aa    = (is_signed && a[31]) ? (32'd0 - a) : a;
	assign ab    = (is_signed && b[31]) ? (32'd0 - b) : b;
	assign trial = {1'b0, rem_q, ma_q[31]} - {2'b00, mb_q};
	assign part  = {16'd0, mb_q} * {32'd0, (cnt_q[0] ? ma_q[31:16] : ma_q[15:0])};
	assign prod  = neg_q ? (64'd0 - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			mul_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (!busy_q && (start_mul || start_div)) begin
				busy_q <= 1'b1;
				mul_q  <= start_mul;
				cnt_q  <= start_mul ? 6'd2 : 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && (start_mul || start_div)) begin
			ma_q   <= aa;
			mb_q   <= ab;
			neg_q  <= is_signed && (a[31] ^ b[31]);
			negr_q <= is_signed && a[31];
			acc_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (mul_q) begin
				if (cnt_q[0]) acc_q <= acc_q + {part, 16'd0};
				else          acc_q <= acc_q + {16'd0, part};
			end else begin
				if (!trial[33]) rem_q <= trial[31:0];
				else            rem_q <= {rem_q[30:0], ma_q[31]};
				quo_q <= {quo_q[30:0], ~trial[33]};
				ma_q  <= {ma_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (mul_q) res = prod;
		else res = {negr_q ? (32'd0 - rem_q) : rem_q, neg_q ? (32'd0 - quo_q) : quo_q};
		hi = res[63:32];
		lo = res[31:0];
	end

endmodule
`default_nettype wire

>>> rtl/miu_back.sv
// ----------------------------------------------------------------------------
// miu_back
// Register file, hi/lo, PC, data memory and the execute sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module miu_back
	import miu_pkg::*;
#(
	parameter int DATA_WORDS = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data,
	input  wire in_item_t    q_data,
	input  wire logic        q_valid,
	output logic             q_pop,
	output out_item_t        out_data,
	output logic             out_valid,
	input  wire logic        out_ready
);

	localparam int AW = $clog2(DATA_WORDS);

	exec_state_t state_q, state_d;
	logic [31:0] rf_q [32];
	logic [31:0] hi_q, lo_q, pc_q;
	logic [31:0] mem [DATA_WORDS];
	logic [31:0] mem_rd_q;
	in_item_t    it_q;
	logic [31:0] a_q, b_q;
	out_item_t   res_q, r;
	logic        res_valid_q;

	logic [31:0] addr, seq, btgt, jtgt, md_hi, md_lo, wval, npc;
	logic [29:0] widx_mem;
	logic        in_range, fault, mis, taken, wen, men, dz, md_done;
	logic [4:0]  widx;
	logic        start_mul, start_div, md_signed;

	assign addr     = a_q + sext16(it_q.imm16);
	assign widx_mem = addr[31:2];
	assign in_range = (widx_mem < 30'(DATA_WORDS));
	assign seq      = pc_q + 32'd4;
	assign btgt     = seq + {{14{it_q.imm16[15]}}, it_q.imm16, 2'b00};
	assign jtgt     = (seq & SEG_MASK) | {4'd0, it_q.jump_target, 2'b00};
	assign start_mul = (state_q == ST_EXEC) &&
		(op_t'(it_q.operation) == OP_MULT || op_t'(it_q.operation) == OP_MULTU);
	assign start_div = (state_q == ST_EXEC) && (b_q != 32'd0) &&
		(op_t'(it_q.operation) == OP_DIV || op_t'(it_q.operation) == OP_DIVU);
	assign md_signed = (op_t'(it_q.operation) == OP_MULT) ||
		(op_t'(it_q.operation) == OP_DIV);

	miu_muldiv u_md (
		.clk, .arst_n, .start_mul, .start_div, .is_signed(md_signed),
		.a(a_q), .b(b_q), .done(md_done), .hi(md_hi), .lo(md_lo)
	);

	always_comb begin
		npc = seq; taken = 1'b0; wen = 1'b0; widx = '0; wval = '0;
		men = 1'b0; dz = 1'b0; mis = 1'b0;
		unique case (op_t'(it_q.operation))
			OP_ADD, OP_ADDU:   begin wen = 1'b1; widx = it_q.dest_reg; wval = a_q + b_q; end
			OP_ADDI, OP_ADDIU: begin wen = 1'b1; widx = it_q.target_reg; wval = addr; end
			OP_AND:  begin wen = 1'b1; widx = it_q.dest_reg; wval = a_q & b_q; end
			OP_ANDI: begin wen = 1'b1; widx = it_q.target_reg; wval = a_q & {16'd0, it_q.imm16}; end
			OP_BEQ:  if (a_q == b_q) begin taken = 1'b1; npc = btgt; end
			OP_BNE:  if (a_q != b_q) begin taken = 1'b1; npc = btgt; end
			OP_BNEZ: if (a_q != 32'd0) begin taken = 1'b1; npc = btgt; end
			OP_J:    begin taken = 1'b1; npc = jtgt; end
			OP_JAL:  begin
				taken = 1'b1; npc = jtgt; wen = 1'b1; widx = LINK_REG; wval = pc_q + 32'd8;
			end
			OP_JR:   begin taken = 1'b1; npc = a_q; end
			OP_LHU:  begin
				mis = addr[0];
				wen = 1'b1; widx = it_q.target_reg;
				wval = addr[1] ? {16'd0, mem_rd_q[31:16]} : {16'd0, mem_rd_q[15:0]};
			end
			OP_LL, OP_LW: begin
				mis = addr[1:0] != 2'b00; wen = 1'b1; widx = it_q.target_reg; wval = mem_rd_q;
			end
			OP_LUI:  begin wen = 1'b1; widx = it_q.target_reg; wval = {it_q.imm16, 16'd0}; end
			OP_NOR:  begin wen = 1'b1; widx = it_q.dest_reg; wval = ~(a_q | b_q); end
			OP_OR:   begin wen = 1'b1; widx = it_q.dest_reg; wval = a_q | b_q; end
			OP_ORI:  begin wen = 1'b1; widx = it_q.target_reg; wval = a_q | {16'd0, it_q.imm16}; end
			OP_SLT:  begin wen = 1'b1; widx = it_q.dest_reg;
				wval = {31'd0, $signed(a_q) < $signed(b_q)}; end
			OP_SLTI: begin wen = 1'b1; widx = it_q.target_reg;
				wval = {31'd0, $signed(a_q) < $signed(sext16(it_q.imm16))}; end
			OP_SLTIU: begin wen = 1'b1; widx = it_q.target_reg;
				wval = {31'd0, a_q < sext16(it_q.imm16)}; end
			OP_SLTU: begin wen = 1'b1; widx = it_q.dest_reg; wval = {31'd0, a_q < b_q}; end
			OP_SLL:  begin wen = 1'b1; widx = it_q.dest_reg; wval = b_q << it_q.shift_amount; end
			OP_SRL:  begin wen = 1'b1; widx = it_q.dest_reg; wval = b_q >> it_q.shift_amount; end
			OP_SW:   begin mis = addr[1:0] != 2'b00; men = 1'b1; end
			OP_SUB, OP_SUBU: begin wen = 1'b1; widx = it_q.dest_reg; wval = a_q - b_q; end
			OP_DIV, OP_DIVU: dz = (b_q == 32'd0);
			OP_MFHI: begin wen = 1'b1; widx = it_q.dest_reg; wval = hi_q; end
			OP_MFLO: begin wen = 1'b1; widx = it_q.dest_reg; wval = lo_q; end
			OP_MULT, OP_MULTU: ;
			OP_MOVE: begin wen = 1'b1; widx = it_q.dest_reg; wval = a_q; end
			OP_LI:   begin wen = 1'b1; widx = it_q.target_reg; wval = it_q.full_value; end
			default: ;
		endcase
		fault = 1'b0;
		if (op_t'(it_q.operation) == OP_LHU || op_t'(it_q.operation) == OP_LL ||
			op_t'(it_q.operation) == OP_LW || op_t'(it_q.operation) == OP_SW) begin
			fault = mis || !in_range;
			if (fault) begin wen = 1'b0; men = 1'b0; end
		end
		if (!wen || widx == 5'd0) begin wen = 1'b0; widx = '0; wval = '0; end
		r.next_pc          = npc;
		r.branch_taken     = taken;
		r.reg_write_enable = wen;
		r.reg_write_index  = widx;
		r.reg_write_value  = wval;
		r.hi_value         = hi_q;
		r.lo_value         = lo_q;
		r.mem_write_enable = men;
		r.mem_word_index   = (fault || !(op_t'(it_q.operation) == OP_LHU ||
			op_t'(it_q.operation) == OP_LL || op_t'(it_q.operation) == OP_LW ||
			op_t'(it_q.operation) == OP_SW)) ? 12'd0 : widx_mem[11:0];
		r.divide_by_zero   = dz;
		r.address_fault    = fault;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (start_mul) state_d = ST_MUL;
				else if (start_div) state_d = ST_DIV;
				else if ((op_t'(it_q.operation) == OP_LHU || op_t'(it_q.operation) == OP_LL ||
					op_t'(it_q.operation) == OP_LW) && !mis && in_range) state_d = ST_MEM;
				else state_d = ST_DONE;
			end
			ST_MUL, ST_DIV: if (md_done) state_d = ST_DONE;
			ST_MEM: state_d = ST_DONE;
			ST_DONE: if (!res_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == ST_IDLE) && q_valid;
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	always_ff @(posedge clk) begin
		if (q_pop) it_q <= q_data;
		if (state_q == ST_EXEC && men && !r.address_fault) mem[widx_mem[AW-1:0]] <= b_q;
		mem_rd_q <= mem[widx_mem[AW-1:0]];
		if (state_q == ST_DONE && (!res_valid_q || out_ready)) res_q <= r;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			a_q <= rf_q[q_data.source_reg];
			b_q <= rf_q[q_data.target_reg];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			hi_q        <= '0;
			lo_q        <= '0;
			pc_q        <= '0;
			for (int i = 0; i < 32; i++) rf_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (out_ready) res_valid_q <= 1'b0;
			if (state_q == ST_DONE && (!res_valid_q || out_ready)) begin
				res_valid_q <= 1'b1;
				pc_q <= r.next_pc;
				if (r.reg_write_enable) rf_q[r.reg_write_index] <= r.reg_write_value;
			end
			if ((state_q == ST_MUL || state_q == ST_DIV) && md_done) begin
				hi_q <= md_hi;
				lo_q <= md_lo;
			end
			if (cfg_we) pc_q <= cfg_data;
		end
	end

endmodule
`default_nettype wire
